// ----- rtl/rgbed_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbed_pkg
// Shared widths, constants and types of the RGB888 to RGB555 error diffusion
// converter.
// ----------------------------------------------------------------------------
package rgbed_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int             ROW_W_W     = 12;
  localparam logic [11:0]    ROW_W_RESET = 12'd640;

  localparam int PIX_W  = 8;
  localparam int ACC_W  = 8;
  localparam int Q_W    = 4;
  localparam int V5_W   = 5;
  localparam int NUM_CH = 3;
  localparam int OUT_W  = NUM_CH * V5_W;
  localparam int WORD_W = NUM_CH * ACC_W;

  typedef logic [NUM_CH-1:0][Q_W-1:0] qvec_t;

  typedef struct packed {
    logic  last;
    logic  bank;
    qvec_t q0;
    qvec_t q1;
    qvec_t q2;
  } rgbed_step_t;

  function automatic logic [ACC_W-1:0] sext_q(input logic [Q_W-1:0] q);
    return {{(ACC_W-Q_W){q[Q_W-1]}}, q};
  endfunction

endpackage

// ----- rtl/rgbed_if.sv -----
// ----------------------------------------------------------------------------
// rgbed_if
// Valid/ready channels of the converter: source pixel in, RGB555 word out.
// ----------------------------------------------------------------------------
interface rgbed_pix_if import rgbed_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             frame_start;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;

  modport source (output valid, frame_start, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, frame_start, red_in, green_in, blue_in, output ready);
endinterface

interface rgbed_px555_if import rgbed_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] pixel_555;

  modport source (output valid, pixel_555, input ready);
  modport sink   (input valid, pixel_555, output ready);
endinterface

// ----- rtl/rgbed_err_ram.sv -----
// ----------------------------------------------------------------------------
// rgbed_err_ram
// Error line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rgbed_err_ram import rgbed_pkg::*; #(
  parameter int AW = $clog2(MAX_WIDTH_DEF) + 1,
  parameter int DW = WORD_W
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rgbed_quant.sv -----
// ----------------------------------------------------------------------------
// rgbed_quant
// One channel: add diffused error, saturate, quantize to 5 bits and form the
// quantization error.
// ----------------------------------------------------------------------------
module rgbed_quant import rgbed_pkg::*; (
  input  logic [PIX_W-1:0] pix,
  input  logic [ACC_W-1:0] acc_mem,
  input  logic [Q_W-1:0]   q_left,
  output logic [V5_W-1:0]  v5,
  output logic [Q_W-1:0]   q
);

  localparam int DIV_SH = 4;

  localparam logic [PIX_W-1:0] LEVEL_TBL [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  logic [ACC_W-1:0]      left8;
  logic [ACC_W-1:0]      acc;
  logic [ACC_W:0]        biased;
  logic [ACC_W-DIV_SH:0] e;
  logic [PIX_W+1:0]      sum;
  logic [PIX_W-1:0]      val;
  logic [PIX_W:0]        diff;

  always_comb begin
    left8  = sext_q(q_left);
    acc    = acc_mem + ((left8 << 3) - left8);
    // round toward zero: bias negative values before the shift
    biased = {acc[ACC_W-1], acc}
           + (acc[ACC_W-1] ? (ACC_W+1)'((1 << DIV_SH) - 1) : '0);
    e      = biased[ACC_W:DIV_SH];
    sum    = {2'b00, pix} + {{(PIX_W+2-(ACC_W+1-DIV_SH)){e[ACC_W-DIV_SH]}}, e};
    if (sum[PIX_W+1]) begin
      val = '0;
    end else if (sum[PIX_W]) begin
      val = '1;
    end else begin
      val = sum[PIX_W-1:0];
    end
    v5   = val[PIX_W-1 -: V5_W];
    diff = {1'b0, val} - {1'b0, LEVEL_TBL[v5]};
    q    = diff[Q_W-1:0];
  end

endmodule

// ----- rtl/rgbed_spread.sv -----
// ----------------------------------------------------------------------------
// rgbed_spread
// Next-row write-back: sums the 1/5/3 weighted errors of three neighboring
// pixels and writes each next-row entry once.
// ----------------------------------------------------------------------------
module rgbed_spread import rgbed_pkg::*; #(
  parameter int COL_W = $clog2(MAX_WIDTH_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [COL_W-1:0]  step_col,
  input  rgbed_step_t       step_info,
  input  logic [COL_W-1:0]  rd_col,
  input  logic              rd_bank,
  output logic              conflict,
  output logic              we,
  output logic [COL_W:0]    waddr,
  output logic [WORD_W-1:0] wdata
);

  logic                          c_valid;
  logic [COL_W-1:0]              c_col;
  rgbed_step_t                   c_info;
  logic                          d_valid;
  logic [COL_W-1:0]              d_col;
  logic                          d_bank;
  logic [NUM_CH-1:0][ACC_W-1:0]  d_word;

  logic                          c_we;
  logic [NUM_CH-1:0][ACC_W-1:0]  c_word;
  logic [NUM_CH-1:0][ACC_W-1:0]  d_word_next;
  logic [ACC_W-1:0]              e0 [NUM_CH];
  logic [ACC_W-1:0]              e1 [NUM_CH];
  logic [ACC_W-1:0]              e2 [NUM_CH];
  logic                          c_in_range;

  always_comb begin
    c_in_range = 1'b1;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      e0[ch] = sext_q(c_info.q0[ch]);
      e1[ch] = sext_q(c_info.q1[ch]);
      e2[ch] = sext_q(c_info.q2[ch]);
      c_word[ch]      = e2[ch] + ((e1[ch] << 2) + e1[ch]) + ((e0[ch] << 1) + e0[ch]);
      d_word_next[ch] = e1[ch] + ((e0[ch] << 2) + e0[ch]);
      c_in_range      = c_in_range && (c_word[ch][ACC_W-1] == c_word[ch][ACC_W-2]);
    end
    c_we = c_valid && (c_col != '0);
    conflict = (c_valid && (c_info.bank == rd_bank)
                && (((c_col != '0) && (c_col - COL_W'(1) == rd_col))
                    || (c_info.last && (c_col == rd_col))))
             || (d_valid && (d_bank == rd_bank) && (d_col == rd_col));
    we = c_we || d_valid;
    if (d_valid) begin
      waddr = {d_bank, d_col};
      wdata = d_word;
    end else begin
      waddr = {c_info.bank, COL_W'(c_col - COL_W'(1))};
      wdata = c_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      c_valid <= step;
      d_valid <= c_valid && c_info.last;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      c_col  <= step_col;
      c_info <= step_info;
    end
    d_col  <= c_col;
    d_bank <= c_info.bank;
    d_word <= d_word_next;
  end

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(c_we && d_valid))
    else $error("row-end write collides with a left-neighbor write");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    (d_valid && c_valid) |-> (c_col == '0))
    else $error("item after a row end is not at column zero");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    c_we |-> c_in_range)
    else $error("next-row error sum out of range");

endmodule

// ----- rtl/rgb888_to_rgb555_error_diffusion.sv -----
// ----------------------------------------------------------------------------
// rgb888_to_rgb555_error_diffusion
// Floyd-Steinberg dithering of RGB888 pixels in raster order to RGB555 words.
// ----------------------------------------------------------------------------
// Each accepted pixel passes the input stage register, then the output register.
// Throughput: one pixel per cycle when neither the output nor a hazard stalls;
//   the right-neighbor error forwards in a register and each next-row error
//   entry is written once to the line store. A row start can wait for the
//   line store write-back when the row before it was at most three pixels wide.
// Reset: row_width 640, column zero, both error rows read as zero; no clear pass.
module rgb888_to_rgb555_error_diffusion import rgbed_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [ROW_W_W-1:0] cfg_wr_data,
  rgbed_pix_if.sink          pix_in,
  rgbed_px555_if.source      pix_out
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int FILL_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (ROW_W_W > FILL_W) ? ROW_W_W : FILL_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WIDTH);
  localparam logic [Q_W-1:0]   Q_MIN   = {1'b1, {(Q_W-1){1'b0}}};

  logic [ROW_W_W-1:0]            row_width;
  logic [COL_W-1:0]              col;
  logic                          bank;
  logic [FILL_W-1:0]             fill;

  logic                          accept;
  logic                          hazard;
  logic                          out_take;
  logic                          b_adv;
  logic                          b_conf;
  logic                          sp_conflict;

  logic [COL_W-1:0]              col_x;
  logic                          bank_x;
  logic [FILL_W-1:0]             fill_x;
  logic [CMP_W-1:0]              col1;
  logic                          last_x;
  logic                          rd_ok_x;

  logic                          s1_valid;
  logic [COL_W-1:0]              s1_col;
  logic                          s1_last;
  logic                          s1_wbank;
  logic                          s1_rd_ok;
  logic [NUM_CH-1:0][PIX_W-1:0]  s1_pix;

  logic [WORD_W-1:0]             rdata;
  qvec_t                         q_hist1;
  qvec_t                         q_hist2;
  qvec_t                         q_left;
  qvec_t                         q_cur;
  logic [NUM_CH-1:0][ACC_W-1:0]  acc_mem;
  logic [NUM_CH-1:0][V5_W-1:0]   v5;

  logic                          o_valid;
  logic [OUT_W-1:0]              o_data;

  rgbed_step_t                   step_info;
  logic                          we;
  logic [COL_W:0]                waddr;
  logic [WORD_W-1:0]             wdata;

  always_comb begin
    col_x   = pix_in.frame_start ? '0 : col;
    bank_x  = pix_in.frame_start ? 1'b0 : bank;
    fill_x  = pix_in.frame_start ? '0 : fill;
    col1    = CMP_W'(col_x) + CMP_W'(1);
    last_x  = (col1 >= CMP_W'(row_width)) || (col1 >= MAX_CMP);
    rd_ok_x = FILL_W'(col_x) < fill_x;

    b_conf = s1_valid && (s1_wbank == bank)
           && (((s1_col != '0) && (s1_col - COL_W'(1) == col))
               || (s1_last && (s1_col == col)));
    hazard = (FILL_W'(col) < fill) && (b_conf || sp_conflict);

    out_take     = !o_valid || pix_out.ready;
    b_adv        = s1_valid && out_take;
    pix_in.ready = (!s1_valid || out_take) && !hazard;
    accept       = pix_in.valid && pix_in.ready;

    pix_out.valid     = o_valid;
    pix_out.pixel_555 = o_data;

    step_info.last = s1_last;
    step_info.bank = s1_wbank;
    step_info.q0   = q_cur;
    step_info.q1   = q_left;
    step_info.q2   = (s1_col > COL_W'(1)) ? q_hist2 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_W_RESET;
      col       <= '0;
      bank      <= 1'b0;
      fill      <= '0;
      s1_valid  <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        row_width <= cfg_wr_data;
      end
      if (accept) begin
        col  <= last_x ? '0 : col1[COL_W-1:0];
        bank <= last_x ? ~bank_x : bank_x;
        fill <= last_x ? col1[FILL_W-1:0] : fill_x;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (b_adv) begin
        s1_valid <= 1'b0;
      end
      if (b_adv) begin
        o_valid <= 1'b1;
      end else if (pix_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col    <= col_x;
      s1_last   <= last_x;
      s1_wbank  <= ~bank_x;
      s1_rd_ok  <= rd_ok_x;
      s1_pix[0] <= pix_in.red_in;
      s1_pix[1] <= pix_in.green_in;
      s1_pix[2] <= pix_in.blue_in;
    end
    if (b_adv) begin
      o_data  <= {v5[0], v5[1], v5[2]};
      q_hist1 <= q_cur;
      q_hist2 <= q_hist1;
    end
  end

  rgbed_err_ram #(
    .AW (COL_W + 1),
    .DW (WORD_W)
  ) u_err_ram (
    .clk   (clk),
    .re    (accept),
    .raddr ({bank_x, col_x}),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    assign acc_mem[ch] = s1_rd_ok ? rdata[ch*ACC_W +: ACC_W] : '0;
    assign q_left[ch]  = (s1_col != '0) ? q_hist1[ch] : '0;

    rgbed_quant u_quant (
      .pix     (s1_pix[ch]),
      .acc_mem (acc_mem[ch]),
      .q_left  (q_left[ch]),
      .v5      (v5[ch]),
      .q       (q_cur[ch])
    );
  end

  rgbed_spread #(
    .COL_W (COL_W)
  ) u_spread (
    .clk       (clk),
    .rst       (rst),
    .step      (b_adv),
    .step_col  (s1_col),
    .step_info (step_info),
    .rd_col    (col),
    .rd_bank   (bank),
    .conflict  (sp_conflict),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_WIDTH))
    else $error("row fill count beyond line store depth");

  a_bank_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !pix_in.frame_start && !last_x) |=> (bank == $past(bank)))
    else $error("row bank switched inside a row");

  a_q_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ((q_cur[0] != Q_MIN) && (q_cur[1] != Q_MIN) && (q_cur[2] != Q_MIN)))
    else $error("quantization error out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_take) |=> (s1_valid && $stable(s1_col)))
    else $error("stalled item lost in quantizer stage");

endmodule

// ----- sim/rgbed_dither_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgbed_dither_checker
// Watches both pixel channels and the row width port of the converter. It
// keeps its own copy of the two error line stores, the column and the bank
// select, and works out the RGB555 word for every accepted source pixel. Each
// accepted output word is compared with the oldest word still owed.
// ----------------------------------------------------------------------------
module rgbed_dither_checker import rgbed_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [ROW_W_W-1:0] cfg_wr_data,
  rgbed_pix_if               pix_in,
  rgbed_px555_if             pix_out,
  output int                 mismatches,
  output int                 outstanding,
  output int                 words_checked
);

  localparam int MAX_W        = MAX_WIDTH_DEF;
  localparam int REPORT_LIMIT = 10;

  logic [ACC_W-1:0]   err_line [2][MAX_W][NUM_CH];
  logic [ROW_W_W-1:0] row_width = ROW_W_RESET;
  logic               cur_bank  = 1'b0;
  int                 column    = 0;
  logic [OUT_W-1:0]   owed_words [$];
  int                 fail_count  = 0;
  int                 match_count = 0;
  int                 word_index  = 0;

  function automatic void wipe_line(input int bank);
    for (int i = 0; i < MAX_W; i++)
      for (int ch = 0; ch < NUM_CH; ch++)
        err_line[bank][i][ch] = '0;
  endfunction

  function automatic void clear_frame();
    wipe_line(0);
    wipe_line(1);
    column   = 0;
    cur_bank = 1'b0;
  endfunction

  function automatic logic [OUT_W-1:0] dither_pixel(input logic frame_first,
      input logic [PIX_W-1:0] comp [NUM_CH]);
    int w;
    int col;
    int here;
    int below;
    int val;
    int q;
    logic [V5_W-1:0] v5 [NUM_CH];
    if (frame_first) clear_frame();
    w = int'(row_width);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    here  = cur_bank ? 1 : 0;
    below = 1 - here;
    col   = (column >= MAX_W) ? MAX_W - 1 : column;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      val = int'(comp[ch]) + int'($signed(err_line[here][col][ch])) / 16;
      if (val > 255) val = 255;
      if (val < 0) val = 0;
      v5[ch] = val[PIX_W-1 -: V5_W];
      q = val - int'(v5[ch]) * 255 / 31;
      if (col + 1 < w) begin
        err_line[here][col+1][ch]  += ACC_W'(q * 7);
        err_line[below][col+1][ch] += ACC_W'(q);
      end
      if (col >= 1) err_line[below][col-1][ch] += ACC_W'(q * 3);
      err_line[below][col][ch] += ACC_W'(q * 5);
    end
    if (col + 1 >= w) begin
      wipe_line(here);
      cur_bank = ~cur_bank;
      column   = 0;
    end else begin
      column = col + 1;
    end
    return {v5[0], v5[1], v5[2]};
  endfunction

  always @(posedge clk) begin
    logic [PIX_W-1:0] comp [NUM_CH];
    logic [OUT_W-1:0] want;
    if (rst) begin
      clear_frame();
      row_width = ROW_W_RESET;
      owed_words.delete();
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (owed_words.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("word %0d: unexpected output %04h with nothing owed",
                     word_index, pix_out.pixel_555);
        end else begin
          want = owed_words.pop_front();
          if (pix_out.pixel_555 !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("word %0d: expected %04h (r%0d g%0d b%0d), got %04h (r%0d g%0d b%0d)",
                       word_index, want, want[14:10], want[9:5], want[4:0],
                       pix_out.pixel_555, pix_out.pixel_555[14:10],
                       pix_out.pixel_555[9:5], pix_out.pixel_555[4:0]);
          end else begin
            match_count++;
          end
        end
        word_index++;
      end
      if (pix_in.valid && pix_in.ready) begin
        comp[0] = pix_in.red_in;
        comp[1] = pix_in.green_in;
        comp[2] = pix_in.blue_in;
        owed_words.push_back(dither_pixel(pix_in.frame_start, comp));
      end
      if (cfg_wr_en) row_width = cfg_wr_data;
    end
    mismatches    <= fail_count;
    outstanding   <= owed_words.size();
    words_checked <= match_count;
  end

endmodule

// ----- sim/rgb888_to_rgb555_error_diffusion_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb888_to_rgb555_error_diffusion_test
// Streams source pixels into the error diffusion converter through a series
// of row widths, from the reset width over the extremes to small random ones,
// with random idling on both channels, a quiet stretch and one long output
// stall. A checker module beside the block predicts every RGB555 word.
// ----------------------------------------------------------------------------
module rgb888_to_rgb555_error_diffusion_test;
  import rgbed_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 8;

  localparam logic [24:0] WARMUP [19] = '{
    {1'b1, 8'd0,   8'd0,   8'd0},
    {1'b0, 8'd255, 8'd255, 8'd255},
    {1'b0, 8'd7,   8'd7,   8'd7},
    {1'b0, 8'd255, 8'd255, 8'd255},
    {1'b0, 8'd248, 8'd248, 8'd248},
    {1'b0, 8'd0,   8'd0,   8'd0},
    {1'b0, 8'd255, 8'd0,   8'd128},
    {1'b0, 8'd0,   8'd255, 8'd127},
    {1'b0, 8'd128, 8'd128, 8'd128},
    {1'b0, 8'd7,   8'd248, 8'd7},
    {1'b0, 8'd0,   8'd255, 8'd0},
    {1'b0, 8'd248, 8'd7,   8'd248},
    {1'b0, 8'd0,   8'd0,   8'd0},
    {1'b0, 8'd255, 8'd255, 8'd255},
    {1'b1, 8'd128, 8'd64,  8'd32},
    {1'b0, 8'd15,  8'd16,  8'd17},
    {1'b0, 8'd100, 8'd200, 8'd50},
    {1'b0, 8'd1,   8'd2,   8'd3},
    {1'b0, 8'd254, 8'd253, 8'd252}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en;
  logic [ROW_W_W-1:0] cfg_wr_data;
  int                 mismatches;
  int                 outstanding;
  int                 words_checked;
  int                 cycle_count    = 0;
  int                 pixels_sent    = 0;
  int                 frames_started = 0;
  int                 widths_used    = 1;
  logic               calm      = 1'b0;
  logic               hold_now  = 1'b0;
  logic               hold_done = 1'b0;
  int                 hold_left = 0;

  rgbed_pix_if   pix_in ();
  rgbed_px555_if pix_out ();

  rgb888_to_rgb555_error_diffusion dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pix_in      (pix_in),
    .pix_out     (pix_out)
  );

  rgbed_dither_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .pix_in        (pix_in),
    .pix_out       (pix_out),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rgb888_to_rgb555_error_diffusion_test NOT OK");
      $finish;
    end
  end

  initial begin
    pix_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out.ready <= 1'b0;
      end else if (calm) begin
        pix_out.ready <= 1'b1;
      end else begin
        pix_out.ready <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return PIX_W'($urandom_range(0, 7));
      1: return PIX_W'($urandom_range(248, 255));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixel(input logic fs, input logic [PIX_W-1:0] r,
      input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    if (!calm && $urandom_range(0, 99) < 20) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pix_in.valid       <= 1'b1;
    pix_in.frame_start <= fs;
    pix_in.red_in      <= r;
    pix_in.green_in    <= g;
    pix_in.blue_in     <= b;
    do @(posedge clk); while (!pix_in.ready);
    pixels_sent++;
    if (fs) frames_started++;
  endtask

  task automatic random_run(input int count, input logic new_frame, input int hold_at);
    logic fs;
    for (int i = 0; i < count; i++) begin
      fs = (i == 0) ? new_frame : ($urandom_range(0, 299) == 0);
      if (i == hold_at) hold_now <= 1'b1;
      push_pixel(fs, pick_level(), pick_level(), pick_level());
    end
  endtask

  task automatic drain();
    pix_in.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic width_phase(input logic [ROW_W_W-1:0] width, input int count,
      input logic new_frame, input int hold_at);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= width;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    widths_used++;
    random_run(count, new_frame, hold_at);
  endtask

  initial begin
    pix_in.valid       = 1'b0;
    pix_in.frame_start = 1'b0;
    pix_in.red_in      = '0;
    pix_in.green_in    = '0;
    pix_in.blue_in     = '0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (WARMUP[i])
      push_pixel(WARMUP[i][24], WARMUP[i][23:16], WARMUP[i][15:8], WARMUP[i][7:0]);
    random_run(130, 1'b0, -1);

    // cut the width while the column is far past it
    width_phase(12'd3, 200, 1'b0, -1);
    width_phase(12'd0, 100, 1'b1, -1);
    width_phase(12'd4095, 250, 1'b0, 120);
    calm <= 1'b1;
    width_phase(12'd2, 200, 1'b0, -1);
    calm <= 1'b0;
    width_phase(12'd1, 100, 1'b1, -1);
    width_phase(12'd2048, 150, 1'b1, -1);
    for (int p = 0; p < 6; p++)
      width_phase(ROW_W_W'($urandom_range(1, 40)), 120, 1'(($urandom_range(0, 1))), -1);
    drain();

    $display("Sent %0d pixels in %0d frames over %0d row widths; %0d words matched.",
             pixels_sent, frames_started, widths_used, words_checked);
    $display("Run covered saturation, widths 0, 1, 2048 and 4095, mid-row width cuts, "
             , "and a %0d-cycle output stall.", HOLD_CYCLES);
    if (mismatches == 0)
      $display("rgb888_to_rgb555_error_diffusion_test OK");
    else
      $display("rgb888_to_rgb555_error_diffusion_test NOT OK");
    $finish;
  end

endmodule
